/* rtl/bfra_pkg.sv */
// Shared types, constants and control records of the best-fit region allocator.
package bfra_pkg;

  localparam int ADDR_BITS      = 24;
  localparam int OFF_W          = 24;
  localparam int SIZE_W         = 25;
  localparam int CAP_W          = 25;
  localparam int FREE_SLOTS_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1048576);
  localparam logic [SIZE_W:0]  ADDR_SPAN = (SIZE_W + 1)'(1) << ADDR_BITS;

  localparam logic       ACT_ALLOC      = 1'b0;
  localparam logic       ACT_RELEASE    = 1'b1;
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE  = 2'd1;
  localparam logic [1:0] STAT_LIST_FULL = 2'd2;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] region_size;
    logic [OFF_W-1:0]  region_offset;
  } req_t;

  typedef struct packed {
    logic [OFF_W-1:0] granted_offset;
    logic [1:0]       status;
  } resp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_A_RD,
    ST_A_CMP,
    ST_A_DECIDE,
    ST_MV_RD,
    ST_MV_WR,
    ST_C_RD,
    ST_C_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic clr_idx;
    logic inc_idx;
    logic rd_en;
    logic rd_last;
    logic scan_cmp;
    logic alloc_fit;
    logic alloc_bump;
    logic alloc_fail;
    logic rel_lower;
    logic rel_full;
    logic rel_append;
    logic co_merge;
    logic move_last;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic at_end;
    logic fit_found;
    logic fit_empties;
    logic bump_ok;
    logic rel_ignore;
    logic rel_bump;
    logic rel_full;
    logic co_match;
    logic move_needed;
  } sts_t;

endpackage

/* rtl/bfra_ctrl.sv */
// Sequencing state machine of the best-fit region allocator.
module bfra_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  bfra_pkg::sts_t sts,
  output bfra_pkg::cmd_t cmd
);
  import bfra_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.is_alloc) begin
          state_next = ST_A_RD;
        end else if (sts.rel_ignore) begin
          state_next = ST_DONE;
        end else if (sts.rel_bump) begin
          cmd.rel_lower = 1'b1;
          state_next    = ST_DONE;
        end else if (sts.rel_full) begin
          cmd.rel_full = 1'b1;
          state_next   = ST_DONE;
        end else begin
          cmd.rel_append = 1'b1;
          cmd.clr_idx    = 1'b1;
          state_next     = ST_C_RD;
        end
      end
      ST_A_RD: begin
        if (sts.at_end) begin
          state_next = ST_A_DECIDE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = ST_A_CMP;
        end
      end
      ST_A_CMP: begin
        cmd.scan_cmp = 1'b1;
        cmd.inc_idx  = 1'b1;
        state_next   = ST_A_RD;
      end
      ST_A_DECIDE: begin
        if (sts.fit_found) begin
          cmd.alloc_fit = 1'b1;
          state_next    = sts.fit_empties ? ST_MV_RD : ST_DONE;
        end else if (sts.bump_ok) begin
          cmd.alloc_bump = 1'b1;
          state_next     = ST_DONE;
        end else begin
          cmd.alloc_fail = 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_MV_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_last = 1'b1;
        state_next  = ST_MV_WR;
      end
      ST_MV_WR: begin
        cmd.move_last = 1'b1;
        state_next    = sts.is_alloc ? ST_DONE : ST_C_RD;
      end
      ST_C_RD: begin
        if (sts.at_end) begin
          state_next = ST_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = ST_C_CMP;
        end
      end
      ST_C_CMP: begin
        if (sts.co_match) begin
          cmd.co_merge = 1'b1;
          cmd.clr_idx  = 1'b1;
          state_next   = sts.move_needed ? ST_MV_RD : ST_C_RD;
        end else begin
          cmd.inc_idx = 1'b1;
          state_next  = ST_C_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/bfra_dp.sv */
// Datapath of the best-fit region allocator: free-list memory, pointers and result word.
module bfra_dp #(
  parameter int FREE_SLOTS = bfra_pkg::FREE_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bfra_pkg::cmd_t              cmd,
  output bfra_pkg::sts_t              sts,
  input  bfra_pkg::req_t              in_word,
  input  logic                        cfg_wen,
  input  logic [bfra_pkg::CAP_W-1:0]  cfg_wdata,
  output bfra_pkg::resp_t             out_word
);
  import bfra_pkg::*;

  localparam int SLOT_W = $clog2(FREE_SLOTS);
  localparam int CNT_W  = $clog2(FREE_SLOTS + 1);
  localparam logic [CAP_W-1:0] SPAN_CAP = CAP_W'(ADDR_SPAN);

  logic [OFF_W-1:0]  start_mem [FREE_SLOTS];
  logic [SIZE_W-1:0] len_mem   [FREE_SLOTS];

  logic [CAP_W-1:0]  cap;
  logic [CAP_W-1:0]  bump;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [SLOT_W-1:0] m_idx;
  logic [OFF_W-1:0]  m_start;
  logic [SIZE_W-1:0] m_len;
  logic [SLOT_W-1:0] tgt;
  logic              best_found;
  logic [SLOT_W-1:0] best_idx;
  logic [OFF_W-1:0]  best_start;
  logic [SIZE_W-1:0] best_len;
  req_t              req;
  resp_t             res;
  logic [OFF_W-1:0]  rd_start;
  logic [SIZE_W-1:0] rd_len;

  logic [CNT_W-1:0]  cnt_m1;
  logic [SLOT_W-1:0] last;
  logic [SLOT_W-1:0] idx_slot;
  logic [SLOT_W-1:0] raddr;
  logic [SIZE_W:0]   rel_end;
  logic [SIZE_W:0]   bump_end;
  logic [CAP_W-1:0]  cap_eff;
  logic [SIZE_W-1:0] sum_i;
  logic [SIZE_W-1:0] sum_m;
  logic              cond_a;
  logic              cond_b;
  logic [SLOT_W-1:0] a_slot;
  logic [SLOT_W-1:0] b_slot;
  logic [OFF_W-1:0]  e_start;
  logic [SIZE_W-1:0] e_len;
  logic              a_last;
  logic [SLOT_W-1:0] merge_slot;
  logic              we;
  logic [SLOT_W-1:0] waddr;
  logic [OFF_W-1:0]  wstart;
  logic [SIZE_W-1:0] wlen;

  assign cnt_m1     = count - CNT_W'(1);
  assign last       = cnt_m1[SLOT_W-1:0];
  assign idx_slot   = idx[SLOT_W-1:0];
  assign raddr      = cmd.rd_last ? last : idx_slot;
  assign rel_end    = {2'b00, req.region_offset} + {1'b0, req.region_size};
  assign bump_end   = {1'b0, bump} + {1'b0, req.region_size};
  assign cap_eff    = (cap > SPAN_CAP) ? SPAN_CAP : cap;
  assign sum_i      = {1'b0, rd_start} + rd_len;
  assign sum_m      = {1'b0, m_start} + m_len;
  assign cond_a     = (sum_i == {1'b0, m_start});
  assign cond_b     = (sum_m == {1'b0, rd_start});
  assign a_slot     = cond_a ? idx_slot : m_idx;
  assign b_slot     = cond_a ? m_idx : idx_slot;
  assign e_start    = cond_a ? rd_start : m_start;
  assign e_len      = rd_len + m_len;
  assign a_last     = (a_slot == last);
  assign merge_slot = a_last ? b_slot : a_slot;

  always_comb begin
    sts.is_alloc    = (req.action == ACT_ALLOC);
    sts.at_end      = (idx == count);
    sts.fit_found   = best_found;
    sts.fit_empties = (best_len == req.region_size);
    sts.bump_ok     = (bump_end <= {1'b0, cap_eff}) && (bump < cap_eff);
    sts.rel_ignore  = (req.region_size == '0) || (rel_end > ADDR_SPAN);
    sts.rel_bump    = (rel_end == {1'b0, bump});
    sts.rel_full    = (count == CNT_W'(FREE_SLOTS));
    sts.co_match    = (idx_slot != m_idx) && (cond_a || cond_b);
    sts.move_needed = !a_last && (b_slot != last);
  end

  always_comb begin
    we     = 1'b0;
    waddr  = '0;
    wstart = '0;
    wlen   = '0;
    if (cmd.alloc_fit) begin
      we     = 1'b1;
      waddr  = best_idx;
      wstart = best_start + req.region_size[OFF_W-1:0];
      wlen   = best_len - req.region_size;
    end else if (cmd.rel_append) begin
      we     = 1'b1;
      waddr  = count[SLOT_W-1:0];
      wstart = req.region_offset;
      wlen   = req.region_size;
    end else if (cmd.co_merge) begin
      we     = 1'b1;
      waddr  = merge_slot;
      wstart = e_start;
      wlen   = e_len;
    end else if (cmd.move_last) begin
      we     = 1'b1;
      waddr  = tgt;
      wstart = rd_start;
      wlen   = rd_len;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      start_mem[waddr] <= wstart;
      len_mem[waddr]   <= wlen;
    end
    if (cmd.rd_en) begin
      rd_start <= start_mem[raddr];
      rd_len   <= len_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap   <= CAP_RESET;
      bump  <= '0;
      count <= '0;
    end else begin
      if (cfg_wen) begin
        cap <= cfg_wdata;
      end
      if (cmd.alloc_bump) begin
        bump <= bump_end[CAP_W-1:0];
      end else if (cmd.rel_lower) begin
        bump <= bump - req.region_size;
      end
      if (cmd.rel_append) begin
        count <= count + CNT_W'(1);
      end else if ((cmd.co_merge && !sts.move_needed) || cmd.move_last) begin
        count <= cnt_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req        <= in_word;
      best_found <= 1'b0;
      res        <= '{granted_offset: '0, status: STAT_OK};
    end
    if (cmd.load_req || cmd.clr_idx) begin
      idx <= '0;
    end else if (cmd.inc_idx) begin
      idx <= idx + CNT_W'(1);
    end
    if (cmd.scan_cmp && (req.region_size <= rd_len) && (!best_found || best_len > rd_len)) begin
      best_found <= 1'b1;
      best_idx   <= idx_slot;
      best_start <= rd_start;
      best_len   <= rd_len;
    end
    if (cmd.alloc_fit) begin
      res.granted_offset <= best_start;
      tgt                <= best_idx;
    end
    if (cmd.alloc_bump) begin
      res.granted_offset <= bump[OFF_W-1:0];
    end
    if (cmd.alloc_fail) begin
      res.status <= STAT_NO_SPACE;
    end
    if (cmd.rel_full) begin
      res.status <= STAT_LIST_FULL;
    end
    if (cmd.rel_append) begin
      m_idx   <= count[SLOT_W-1:0];
      m_start <= req.region_offset;
      m_len   <= req.region_size;
    end
    if (cmd.co_merge) begin
      m_idx   <= merge_slot;
      m_start <= e_start;
      m_len   <= e_len;
      tgt     <= b_slot;
    end
    if (cmd.out_load) begin
      out_word <= res;
    end
  end

  // The free list never holds more entries than it has slots.
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(FREE_SLOTS))
    else $error("Free-list count exceeds the number of slots.");

  // The bump pointer never passes the end of the address space.
  assert property (@(posedge clk) disable iff (rst) {1'b0, bump} <= ADDR_SPAN)
    else $error("Bump pointer beyond the address space.");

  // An entry is only ever moved out of a list that holds one.
  assert property (@(posedge clk) disable iff (rst) cmd.move_last |-> count != '0)
    else $error("Entry moved from an empty free list.");

endmodule

/* rtl/best_fit_region_allocator.sv */
// Top level of the best-fit region allocator with a coalescing free list.
// An allocate scans all N free entries, reading and then comparing each, and when the
// chosen range empties, the last entry moves into its slot before the answer.
// A release that is ignored, lowers the bump pointer or is dropped answers without a scan; an
// appended range is followed by a final scan of the N entries, and each merge
// restarts the scan and moves the last entry when needed. One word is in flight at a
// time, taken only once the controller is idle after the previous result is loaded; the
// memory read port sets the pace. Synchronous reset empties the list, zeroes the bump
// pointer and sets the capacity to 1048576; the memory needs no clearing pass.
module best_fit_region_allocator #(
  parameter int FREE_SLOTS = bfra_pkg::FREE_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bfra_pkg::req_t             in_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bfra_pkg::resp_t            out_word,
  input  logic                       cfg_wen,
  input  logic [bfra_pkg::CAP_W-1:0] cfg_wdata
);
  import bfra_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bfra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfra_dp #(
    .FREE_SLOTS (FREE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_word   (in_word),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .out_word  (out_word)
  );

endmodule

/* tb/sv/tb_best_fit_region_allocator.sv */
// Self-checking testbench of the best-fit region allocator with directed and random words.
`timescale 1ns / 100ps
module tb_best_fit_region_allocator;
  import bfra_pkg::*;

  localparam int SLOTS = 16;
  localparam int LIMIT = 4000000;
  localparam int N_RAND = 1600;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_wen;
  req_t in_word;
  resp_t out_word;
  logic [CAP_W-1:0] cfg_wdata;

  best_fit_region_allocator u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  logic [63:0] m_start [SLOTS];
  logic [63:0] m_len [SLOTS];
  int unsigned m_count;
  logic [63:0] m_bump;
  logic [63:0] m_cap;
  resp_t grant_q[$];
  int mismatches, cycles;
  logic calm;

  typedef struct {
    logic act;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0] off;
    logic typed;
    logic [1:0] stat;
    logic [OFF_W-1:0] grant;
  } row_t;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void drop_entry(input int unsigned s);
    m_start[s] = m_start[m_count-1];
    m_len[s] = m_len[m_count-1];
    m_count--;
  endfunction

  function automatic void merge_free(input int unsigned m);
    int unsigned i, keep;
    i = 0;
    while (i < m_count) begin
      if (i != m && m_start[i] + m_len[i] == m_start[m]) begin
        keep = i;
        m_len[i] += m_len[m];
        if (keep == m_count - 1) keep = m;
        drop_entry(m);
        m = keep;
        i = 0;
      end else if (i != m && m_start[m] + m_len[m] == m_start[i]) begin
        keep = m;
        m_len[m] += m_len[i];
        if (keep == m_count - 1) keep = i;
        drop_entry(i);
        m = keep;
        i = 0;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic resp_t predict_grant(input req_t r);
    resp_t o;
    int unsigned best, i;
    logic [63:0] cap, sz, en;
    o.granted_offset = '0;
    o.status = STAT_OK;
    sz = 64'(r.region_size);
    if (r.action == ACT_ALLOC) begin
      best = SLOTS;
      cap = (m_cap < 64'(ADDR_SPAN)) ? m_cap : 64'(ADDR_SPAN);
      for (i = 0; i < m_count; i++)
        if (sz <= m_len[i] && (best == SLOTS || m_len[best] > m_len[i])) best = i;
      if (best != SLOTS) begin
        o.granted_offset = m_start[best][OFF_W-1:0];
        m_start[best] += sz;
        m_len[best] -= sz;
        if (m_len[best] == 0) drop_entry(best);
      end else if (m_bump + sz <= cap && m_bump < cap) begin
        o.granted_offset = m_bump[OFF_W-1:0];
        m_bump += sz;
      end else begin
        o.status = STAT_NO_SPACE;
      end
    end else begin
      en = 64'(r.region_offset) + sz;
      if (sz != 0 && en <= 64'(ADDR_SPAN)) begin
        if (en == m_bump) m_bump -= sz;
        else if (m_count >= SLOTS) o.status = STAT_LIST_FULL;
        else begin
          m_start[m_count] = 64'(r.region_offset);
          m_len[m_count] = sz;
          m_count++;
          merge_free(m_count - 1);
        end
      end
    end
    return o;
  endfunction

  // Receiver side: random stalls and the check against the oldest expectation.
  always @(posedge clk) begin
    resp_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", out_word);
        end else begin
          e = grant_q.pop_front();
          if (out_word.granted_offset !== e.granted_offset || out_word.status !== e.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected offset %h status %0d, got offset %h status %0d",
                       e.granted_offset, e.status, out_word.granted_offset, out_word.status);
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
    end
  end

  task automatic send_word(input req_t r, input logic typed, input resp_t tr);
    resp_t p;
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    p = predict_grant(r);
    if (typed && p !== tr) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %h vs %h", tr, p);
    end
    grant_q.insert(grant_q.size(), typed ? tr : p);
    in_word <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    cfg_wdata <= v;
    cfg_wen <= 1'b1;
    @(posedge clk);
    cfg_wen <= 1'b0;
    m_cap = 64'(v);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 5) return '0;
    if (k < 70) return SIZE_W'($urandom_range(256, 1));
    if (k < 92) return SIZE_W'($urandom_range(65536, 1));
    return SIZE_W'($urandom);
  endfunction

  initial begin
    row_t rows[$];
    row_t w;
    req_t r;
    resp_t tr;
    logic [OFF_W-1:0] held_off[$];
    logic [SIZE_W-1:0] held_sz[$];
    int n, k, j;
    mismatches = 0;
    calm = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    rst = 1'b1;
    m_count = 0;
    m_bump = 0;
    m_cap = 64'(CAP_RESET);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows = '{
      '{ACT_ALLOC, 25'd0, 24'hFFFFFF, 1, STAT_OK, 24'd0},
      '{ACT_ALLOC, 25'd100, 24'd0, 1, STAT_OK, 24'd0},
      '{ACT_ALLOC, 25'd100, 24'd0, 1, STAT_OK, 24'd100},
      '{ACT_ALLOC, 25'h1FFFFFF, 24'd0, 1, STAT_NO_SPACE, 24'd0},
      '{ACT_ALLOC, 25'd1048576, 24'd0, 1, STAT_NO_SPACE, 24'd0},
      '{ACT_RELEASE, 25'd0, 24'd50, 1, STAT_OK, 24'd0},
      '{ACT_RELEASE, 25'd20, 24'hFFFFFF, 1, STAT_OK, 24'd0},
      '{ACT_RELEASE, 25'd50, 24'd0, 0, 0, 0},
      '{ACT_ALLOC, 25'd10, 24'd0, 0, 0, 0},
      '{ACT_ALLOC, 25'd40, 24'd0, 0, 0, 0},
      '{ACT_RELEASE, 25'd50, 24'd150, 0, 0, 0},
      '{ACT_RELEASE, 25'd1, 24'hFFFFFF, 0, 0, 0},
      '{ACT_ALLOC, 25'd0, 24'd0, 0, 0, 0},
      '{ACT_ALLOC, 25'd1, 24'd0, 0, 0, 0},
      '{ACT_RELEASE, 25'd5, 24'd300, 0, 0, 0},
      '{ACT_RELEASE, 25'd5, 24'd310, 0, 0, 0},
      '{ACT_RELEASE, 25'd5, 24'd305, 0, 0, 0}
    };
    foreach (rows[i]) begin
      w = rows[i];
      r.action = w.act; r.region_size = w.size; r.region_offset = w.off;
      tr.granted_offset = w.grant; tr.status = w.stat;
      send_word(r, w.typed, tr);
    end
    // Fill the free list with isolated ranges to reach the full-list case.
    for (j = 0; j < 18; j++) begin
      r.action = ACT_RELEASE; r.region_size = 25'd2;
      r.region_offset = OFF_W'(1000 + 10 * j);
      send_word(r, 0, tr);
    end

    write_capacity(25'h1FFFFFF);
    r.action = ACT_ALLOC; r.region_size = 25'd1 << 24; r.region_offset = '0;
    send_word(r, 0, tr);
    write_capacity(25'd0);
    r.region_size = 25'd0;
    send_word(r, 0, tr);
    r.region_size = 25'd3;
    send_word(r, 0, tr);

    n = 0;
    while (n < N_RAND) begin
      calm = (n >= 600 && n < 800);
      if (n % 400 == 0) begin
        k = $urandom_range(3);
        write_capacity(k == 0 ? 25'h1FFFFFF : k == 1 ? 25'd4096 :
                       k == 2 ? CAP_RESET : CAP_W'($urandom));
        if (n % 800 == 0) begin
          // Give most memory back so the bump pointer can move again.
          while (held_off.size() > 0) begin
            r.action = ACT_RELEASE;
            r.region_offset = held_off.pop_back();
            r.region_size = held_sz.pop_back();
            send_word(r, 0, tr);
            n++;
          end
        end
      end
      k = $urandom_range(99);
      if (k < 55 || held_off.size() == 0) begin
        r.action = ACT_ALLOC;
        r.region_size = pick_size();
        r.region_offset = OFF_W'($urandom);
        j = grant_q.size();
        send_word(r, 0, tr);
        tr = grant_q[grant_q.size()-1];
        if (tr.status == STAT_OK && r.region_size != 0) begin
          held_off.insert(held_off.size(), tr.granted_offset);
          held_sz.insert(held_sz.size(), r.region_size);
        end
      end else if (k < 92) begin
        j = $urandom_range(held_off.size() - 1);
        r.action = ACT_RELEASE;
        r.region_offset = held_off[j];
        r.region_size = held_sz[j];
        held_off.delete(j);
        held_sz.delete(j);
        send_word(r, 0, tr);
      end else begin
        r.action = ACT_RELEASE;
        r.region_size = pick_size();
        r.region_offset = OFF_W'($urandom);
        send_word(r, 0, tr);
      end
      n++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (grant_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

/* filelist.f */
rtl/bfra_pkg.sv
rtl/bfra_ctrl.sv
rtl/bfra_dp.sv
rtl/best_fit_region_allocator.sv
tb/sv/tb_best_fit_region_allocator.sv
